// ===== rtl/bls_pkg.sv =====
`default_nettype none

package bls_pkg;

	localparam int WORD_W = 32;
	localparam int CAP_W  = 7;

	localparam logic [WORD_W-1:0] UNDERFLOW_WORD = 32'hFFF0_BDC1;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_SHOW = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_PUSH   = 2'd1,
		OP_POP    = 2'd2,
		OP_ROTATE = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SHOW = 1'b1
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/bls_cell.sv =====
`default_nettype none

module bls_cell import bls_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	input  op_t              op,
	input  wire [WORD_W-1:0] left_word,
	input  wire              left_valid,
	input  wire [WORD_W-1:0] right_word,
	input  wire              right_valid,
	input  wire [WORD_W-1:0] head_word,
	output logic [WORD_W-1:0] word,
	output logic              valid
);

	logic [WORD_W-1:0] word_q;
	logic              valid_q;
	logic              tail;

	assign tail  = valid_q && !right_valid;
	assign word  = word_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_PUSH:   valid_q <= left_valid;
				OP_POP:    valid_q <= right_valid;
				OP_ROTATE: valid_q <= valid_q;
				OP_HOLD:   valid_q <= valid_q;
			endcase
		end
	end

	// rotate: tail cell wraps the head word around to the bottom of the filled run
	always_ff @(posedge clk) begin
		unique case (op)
			OP_PUSH:   word_q <= left_word;
			OP_POP:    word_q <= right_word;
			OP_ROTATE: word_q <= tail ? head_word : right_word;
			OP_HOLD:   word_q <= word_q;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/bls_ctrl.sv =====
`default_nettype none

module bls_ctrl import bls_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [1:0]        cmd,
	input  wire [WORD_W-1:0] push_value,
	input  wire              cfg_we,
	input  wire [CAP_W-1:0]  cfg_wdata,
	input  wire [WORD_W-1:0] head_word,
	output logic             busy,
	output op_t              op,
	output logic             result_valid,
	output logic [WORD_W-1:0] value,
	output logic [1:0]       status,
	output logic             is_empty,
	output logic             is_full,
	output logic             last
);

	localparam int CW = $clog2(DEPTH + 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     rem_q, rem_d;
	logic [CAP_W-1:0]  capacity_q;
	logic [CW-1:0]     eff_cap;
	logic              accept;

	logic              res_en;
	logic [WORD_W-1:0] res_value;
	status_t           res_status;
	logic              res_empty;
	logic              res_full;
	logic              res_last;

	logic              result_valid_q;
	logic [WORD_W-1:0] value_q;
	status_t           status_q;
	logic              is_empty_q;
	logic              is_full_q;
	logic              last_q;

	always_comb begin
		if (capacity_q > CAP_W'(DEPTH)) begin
			eff_cap = CW'(DEPTH);
		end else if (capacity_q == '0) begin
			eff_cap = CW'(1);
		end else begin
			eff_cap = capacity_q[CW-1:0];
		end
	end

	assign busy   = (state_q == ST_SHOW);
	assign accept = start && !busy;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rem_d      = rem_q;
		op         = OP_HOLD;
		res_en     = 1'b0;
		res_value  = head_word;
		res_status = STAT_OK;
		res_empty  = (count_q == '0);
		res_full   = (count_q >= eff_cap);
		res_last   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(cmd))
						CMD_PUSH: begin
							res_en    = 1'b1;
							res_value = push_value;
							if (count_q >= eff_cap) begin
								res_status = STAT_OVERFLOW;
							end else begin
								op        = OP_PUSH;
								count_d   = count_q + CW'(1);
								res_empty = 1'b0;
								res_full  = (count_d >= eff_cap);
							end
						end
						CMD_POP: begin
							res_en = 1'b1;
							if (count_q == '0) begin
								res_value  = UNDERFLOW_WORD;
								res_status = STAT_UNDERFLOW;
							end else begin
								op        = OP_POP;
								count_d   = count_q - CW'(1);
								res_empty = (count_d == '0);
								res_full  = (count_d >= eff_cap);
							end
						end
						CMD_SHOW: begin
							if (count_q == '0) begin
								res_en     = 1'b1;
								res_value  = '0;
								res_status = STAT_UNDERFLOW;
							end else begin
								state_d = ST_SHOW;
								rem_d   = count_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SHOW: begin
				op       = OP_ROTATE;
				res_en   = 1'b1;
				res_last = (rem_q == CW'(1));
				rem_d    = rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			rem_q          <= '0;
			capacity_q     <= CAP_W'(64);
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			count_q        <= count_d;
			rem_q          <= rem_d;
			result_valid_q <= res_en;
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_en) begin
			value_q    <= res_value;
			status_q   <= res_status;
			is_empty_q <= res_empty;
			is_full_q  <= res_full;
			last_q     <= res_last;
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign status       = status_q;
	assign is_empty     = is_empty_q;
	assign is_full      = is_full_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ===== rtl/bounded_lifo_stack.sv =====
// Bounded LIFO stack of signed 32-bit words, built as a row of shift cells
// with the top of stack in cell 0.
// Command side: cmd and push_value are taken at a clock edge where start is
// high and busy is low. Commands: push, pop, show (top to bottom); code 3 is
// ignored. Config: cfg_we/cfg_wdata write the capacity register (0 acts as 1,
// above DEPTH acts as DEPTH); write it only while the stack is idle.
// Result side: each result sits on value/status/is_empty/is_full/last for
// exactly one cycle with result_valid high; the receiver cannot stall.
// A result appears the cycle after its command edge (push, pop, empty
// show); for a show the command edge first sets the show state, and the
// first word then passes through the result register; then one word per cycle.
// Push and pop can be taken back to back. A show holds busy high while it
// walks its entries and the cell row rotates one position per cycle, so the
// next command is taken only once the show is done.
// Reset (arst_n low): the stack is empty, capacity is 64, no result pending.
// Words in the cells are not cleared; only filled cells are ever read.
`default_nettype none

module bounded_lifo_stack import bls_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire [1:0]         cmd,
	input  wire signed [31:0] push_value,
	input  wire               cfg_we,
	input  wire [6:0]         cfg_wdata,
	output logic              result_valid,
	output logic signed [31:0] value,
	output logic [1:0]        status,
	output logic              is_empty,
	output logic              is_full,
	output logic              last
);

	op_t               op;
	logic [WORD_W-1:0] word_w  [DEPTH];
	logic              valid_w [DEPTH];

	bls_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.push_value  (push_value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.head_word   (word_w[0]),
		.busy        (busy),
		.op          (op),
		.result_valid(result_valid),
		.value       (value),
		.status      (status),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.last        (last)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] lw, rw;
		logic              lv, rv;

		if (i == 0) begin : g_first
			assign lw = push_value;
			assign lv = 1'b1;
		end else begin : g_mid_l
			assign lw = word_w[i-1];
			assign lv = valid_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign rw = '0;
			assign rv = 1'b0;
		end else begin : g_mid_r
			assign rw = word_w[i+1];
			assign rv = valid_w[i+1];
		end

		bls_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.left_word  (lw),
			.left_valid (lv),
			.right_word (rw),
			.right_valid(rv),
			.head_word  (word_w[0]),
			.word       (word_w[i]),
			.valid      (valid_w[i])
		);
	end

endmodule

`default_nettype wire

// ===== rtl/bls_checker.sv =====
`default_nettype none

module bls_checker import bls_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        busy,
	input wire        result_valid,
	input wire [1:0]  status,
	input wire        is_empty,
	input wire        is_full,
	input wire        last
);

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STAT_UNDERFLOW) |-> is_empty)
		else $error("underflow transaction without empty flag");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STAT_OVERFLOW) |-> is_full)
		else $error("overflow transaction without full flag");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(is_empty && is_full))
		else $error("empty and full flagged together");

	a_show_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |=> result_valid)
		else $error("show walk stopped before its last transaction");

	a_show_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last) |-> busy)
		else $error("non-final transaction while not busy");

endmodule

bind bounded_lifo_stack bls_checker u_bls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.result_valid(result_valid),
	.status      (status),
	.is_empty    (is_empty),
	.is_full     (is_full),
	.last        (last)
);

`default_nettype wire
